[src/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define U2A_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define U2A_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define U2A_ASSERT(label, clk, rst_n, prop, msg)
`define U2A_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

[src/u2a_pkg.sv]
`timescale 1ns / 1ps

package u2a_pkg;

    localparam int VALUE_W   = 32;
    localparam int TYPE_W    = 3;
    localparam int CHAR_W    = 8;
    localparam int NIBBLE_W  = 4;
    localparam int MAX_DIGITS = 10;
    localparam int BCD_W     = MAX_DIGITS * NIBBLE_W;
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int ITER_W    = $clog2(VALUE_W);

    typedef logic [TYPE_W-1:0]   t_req_type;
    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [NIBBLE_W-1:0] t_nibble;

    localparam t_req_type REQ_DEC      = 3'd0;
    localparam t_req_type REQ_HEX_AUTO = 3'd1;
    localparam t_req_type REQ_HEX8     = 3'd2;
    localparam t_req_type REQ_HEX4     = 3'd3;
    localparam t_req_type REQ_HEX2     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_EMIT
    } t_state;

    function automatic t_char glyph(input t_nibble nib);
        t_char code;
        if (nib < 4'd10) begin
            code = 8'h30 + {4'd0, nib};
        end else begin
            code = 8'h37 + {4'd0, nib};
        end
        return code;
    endfunction

endpackage

[src/u2a_if.sv]
`timescale 1ns / 1ps

interface u2a_req_if import u2a_pkg::*; ();
    logic      valid;
    logic      ready;
    t_req_type req_type;
    t_value    value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink (input valid, input req_type, input value, output ready);
endinterface

interface u2a_char_if import u2a_pkg::*; ();
    logic  valid;
    logic  ready;
    t_char ascii_char;
    logic  last;

    modport source (output valid, output ascii_char, output last, input ready);
    modport sink (input valid, input ascii_char, input last, output ready);
endinterface

[src/unsigned_to_ascii_formatter.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Formats one 32-bit unsigned value per request transaction as ASCII digits,
// most significant first, one character per output transaction, with last set
// on the final character. The block takes one request at a time: i_req.ready
// is high only while idle. Hex modes send 2, 4 or 8 characters. Decimal runs a
// shift-and-add-3 converter over all 32 input bits, then drops leading zeros at
// one digit per cycle, keeping at least one, then sends 1 to 10 characters at
// one per cycle while o_char.ready is high. Selector codes 5 to 7 are accepted
// and produce no characters.
module unsigned_to_ascii_formatter
    import u2a_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    u2a_req_if.sink      i_req,
    u2a_char_if.source   o_char
);

    t_state               r_state, n_state;
    logic [BCD_W-1:0]     r_digits, n_digits;
    t_value               r_bin, n_bin;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [ITER_W-1:0]    r_iter, n_iter;

    logic                 req_fire;
    logic                 char_fire;
    logic                 req_hex;
    logic                 top_zero;
    logic [BCD_W-1:0]     adj_digits;

    assign req_fire  = i_req.valid && i_req.ready;
    assign char_fire = o_char.valid && o_char.ready;
    assign req_hex   = i_req.req_type inside {REQ_HEX_AUTO, REQ_HEX8, REQ_HEX4, REQ_HEX2};
    assign top_zero  = (r_digits[BCD_W-1 -: NIBBLE_W] == '0);

    // add-3 correction on every bcd digit
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_digits[d*NIBBLE_W +: NIBBLE_W] >= 4'd5) begin
                adj_digits[d*NIBBLE_W +: NIBBLE_W] = r_digits[d*NIBBLE_W +: NIBBLE_W] + 4'd3;
            end else begin
                adj_digits[d*NIBBLE_W +: NIBBLE_W] = r_digits[d*NIBBLE_W +: NIBBLE_W];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    case (i_req.req_type)
                        REQ_DEC:      n_state = ST_CONV;
                        REQ_HEX_AUTO,
                        REQ_HEX8,
                        REQ_HEX4,
                        REQ_HEX2:     n_state = ST_EMIT;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CONV: begin
                if (r_iter == ITER_W'(VALUE_W - 1)) begin
                    n_state = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (!top_zero || r_cnt == CNT_W'(1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (char_fire && r_cnt == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_digits = r_digits;
        n_bin    = r_bin;
        n_cnt    = r_cnt;
        n_iter   = r_iter;
        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    case (i_req.req_type)
                        REQ_DEC: begin
                            n_bin    = i_req.value;
                            n_digits = '0;
                            n_iter   = '0;
                            n_cnt    = CNT_W'(MAX_DIGITS);
                        end
                        REQ_HEX_AUTO: begin
                            if (i_req.value[31:16] != '0) begin
                                n_digits = {i_req.value, 8'd0};
                                n_cnt    = CNT_W'(8);
                            end else if (i_req.value[15:8] != '0) begin
                                n_digits = {i_req.value[15:0], 24'd0};
                                n_cnt    = CNT_W'(4);
                            end else begin
                                n_digits = {i_req.value[7:0], 32'd0};
                                n_cnt    = CNT_W'(2);
                            end
                        end
                        REQ_HEX8: begin
                            n_digits = {i_req.value, 8'd0};
                            n_cnt    = CNT_W'(8);
                        end
                        REQ_HEX4: begin
                            n_digits = {i_req.value[15:0], 24'd0};
                            n_cnt    = CNT_W'(4);
                        end
                        REQ_HEX2: begin
                            n_digits = {i_req.value[7:0], 32'd0};
                            n_cnt    = CNT_W'(2);
                        end
                        default: begin
                            n_cnt = r_cnt;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                n_digits = {adj_digits[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin    = {r_bin[VALUE_W-2:0], 1'b0};
                n_iter   = r_iter + ITER_W'(1);
            end
            ST_STRIP: begin
                if (top_zero && r_cnt != CNT_W'(1)) begin
                    n_digits = {r_digits[BCD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
                    n_cnt    = r_cnt - CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (char_fire) begin
                    n_digits = {r_digits[BCD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
                    n_cnt    = r_cnt - CNT_W'(1);
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_char.valid      = (r_state == ST_EMIT);
    assign o_char.ascii_char = glyph(r_digits[BCD_W-1 -: NIBBLE_W]);
    assign o_char.last       = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_iter  <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_bin    <= n_bin;
    end

    `U2A_NEVER(a_emit_empty, i_clk, i_rst_n, o_char.valid && r_cnt == '0, "emit with no digits left")
    `U2A_NEVER(a_ready_while_busy, i_clk, i_rst_n, i_req.ready && o_char.valid, "request taken during emit")
    `U2A_ASSERT(a_last_ends, i_clk, i_rst_n, char_fire && o_char.last |=> i_req.ready, "no return to idle")
    `U2A_ASSERT(a_hex_starts, i_clk, i_rst_n, req_fire && req_hex |=> o_char.valid, "hex did not start emit")
    `U2A_ASSERT(a_strip_keeps_one, i_clk, i_rst_n, r_state == ST_STRIP |-> r_cnt != '0, "all digits stripped")

endmodule
